// File: hw/rtl/pcss_pkg.sv
// Shared types and constants for the per-CPU scheduling statistics counter.
// Holds the per-CPU record layout, request and status codes and config indexes.
// No dependencies.
`timescale 1ns / 1ps

package pcss_pkg;

	localparam int NUM_CPUS = 4;
	localparam int CPU_W    = $clog2(NUM_CPUS);

	localparam int IN_TDATA_W  = 152;
	localparam int OUT_TDATA_W = 488;

	localparam logic [5:0]  HP_LIMIT_RST  = 6'd16;
	localparam logic [9:0]  TICK_IRQ_RST  = 10'd29;
	localparam logic [10:0] IPI_LIMIT_RST = 11'd16;

	typedef enum logic [2:0] {
		REQ_SWITCH = 3'd0,
		REQ_SPIN   = 3'd1,
		REQ_IRQ    = 3'd2,
		REQ_SEED   = 3'd3,
		REQ_START  = 3'd4,
		REQ_CLOSE  = 3'd5
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ALREADY     = 2'd1,
		ST_NOT_STARTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_HP_LIMIT  = 2'd0,
		CFG_TICK_IRQ  = 2'd1,
		CFG_IPI_LIMIT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0] idle_start;
		logic [63:0] idle_accum;
		logic [63:0] high_start;
		logic [63:0] high_accum;
		logic [63:0] spin_accum;
		logic [63:0] prio_accum;
		logic [31:0] prio_sw;
		logic [31:0] high_sw;
		logic [31:0] ctx_sw;
		logic [31:0] hwi_cnt;
		logic [31:0] ipi_cnt;
	} pcss_rec_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [CPU_W-1:0] cpu;
		logic             old_idle;
		logic             new_idle;
		logic [4:0]       old_priority;
		logic [4:0]       new_priority;
		logic [63:0]      now;
		logic [63:0]      spin_time;
		logic [9:0]       irq_number;
		logic             last_cpu;
	} pcss_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CPU_W-1:0] cpu_out;
		logic [63:0]      elapsed;
		logic [63:0]      idle_time;
		logic [63:0]      high_time;
		logic [63:0]      spin_total;
		logic [63:0]      priority_sum;
		logic [31:0]      priority_count;
		logic [31:0]      high_count;
		logic [31:0]      switch_count;
		logic [31:0]      irq_count;
		logic [31:0]      ipi_count;
	} pcss_res_t;

	typedef struct packed {
		logic [5:0]  hp_limit;
		logic [9:0]  tick_irq;
		logic [10:0] ipi_limit;
	} pcss_cfg_t;

	typedef struct packed {
		logic        enabled;
		logic [63:0] start_time;
	} pcss_glob_t;

endpackage

// File: hw/rtl/per_cpu_sched_stats_counter.sv
// Top level of the per-CPU scheduling statistics counter.
// Depends on pcss_pkg, pcss_rec_mem and pcss_update.
//
// Usage:
//   s_* carries request beats: s_tuser is the request type, s_tlast marks the
//   close of the final CPU, s_tdata the event fields. m_* carries one result
//   beat for each seed, start and close request; other requests return none.
//   cfg_we/cfg_addr/cfg_wdata write the three limit registers; write them only
//   while no request is in flight.
//   Flow: an accepted request is registered into s1 together with its CPU record
//   read; the update is applied there, and when s1 advances the record is written
//   back and the result is registered into the output register behind m_tvalid.
//   Throughput: one request per cycle while s_tready is high. The per-CPU record
//   is read at accept and written back when s1 advances; a back-to-back hit on the
//   same CPU is served from the write-back data.
//   Reset: limits return to 16 / 29 / 16, the monitor is disabled and every CPU
//   record reads as zero at once (per-entry valid bits, no clearing pass).
//   Stall: one result waits in the output register while later requests keep
//   flowing; s_tready drops only when a result-bearing request meets a full,
//   stalled output register.
`timescale 1ns / 1ps

module per_cpu_sched_stats_counter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_addr,
	input  logic [10:0]                      cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cpu, old_idle, new_idle, old_priority, new_priority, now, spin_time, irq_number
	input  logic [pcss_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [2:0]                       s_tuser,   // req_type
	input  logic                             s_tlast,   // last_cpu
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// cpu_out, elapsed, idle_time, high_time, spin_total, priority_sum,
	// priority_count, high_count, switch_count, irq_count, ipi_count, zero pad
	output logic [pcss_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [1:0]                       m_tuser    // status
);
	import pcss_pkg::*;

	pcss_cfg_t  cfg_q;
	pcss_glob_t glob_q;
	pcss_glob_t glob_nxt;
	pcss_item_t in_item;
	pcss_item_t item_s1;
	logic       valid_s1;
	pcss_rec_t  rec_rd;
	pcss_rec_t  rec_nxt;
	pcss_res_t  res;
	logic       res_valid;
	pcss_res_t  res_q;
	logic       out_valid_q;
	logic       adv_s1;
	logic       accept;

	assign in_item.req_type     = s_tuser;
	assign in_item.cpu          = s_tdata[1:0];
	assign in_item.old_idle     = s_tdata[2];
	assign in_item.new_idle     = s_tdata[3];
	assign in_item.old_priority = s_tdata[8:4];
	assign in_item.new_priority = s_tdata[13:9];
	assign in_item.now          = s_tdata[77:14];
	assign in_item.spin_time    = s_tdata[141:78];
	assign in_item.irq_number   = s_tdata[151:142];
	assign in_item.last_cpu     = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hp_limit  <= HP_LIMIT_RST;
			cfg_q.tick_irq  <= TICK_IRQ_RST;
			cfg_q.ipi_limit <= IPI_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_HP_LIMIT:  cfg_q.hp_limit  <= cfg_wdata[5:0];
				CFG_TICK_IRQ:  cfg_q.tick_irq  <= cfg_wdata[9:0];
				CFG_IPI_LIMIT: cfg_q.ipi_limit <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// s1 holds only if its result cannot be parked in the output register
	assign adv_s1   = valid_s1 && (!res_valid || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	pcss_rec_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_item.cpu),
		.wr_en   (adv_s1),
		.wr_addr (item_s1.cpu),
		.wr_data (rec_nxt),
		.rd_data (rec_rd)
	);

	pcss_update u_upd (
		.item      (item_s1),
		.rec       (rec_rd),
		.cfg       (cfg_q),
		.glob      (glob_q),
		.rec_nxt   (rec_nxt),
		.glob_nxt  (glob_nxt),
		.res       (res),
		.res_valid (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glob_q <= '0;
		end else if (adv_s1) begin
			glob_q <= glob_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {6'd0, res_q.ipi_count, res_q.irq_count, res_q.switch_count,
		res_q.high_count, res_q.priority_count, res_q.priority_sum, res_q.spin_total,
		res_q.high_time, res_q.idle_time, res_q.elapsed, res_q.cpu_out};

	// input stalls only behind a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s_tready) |-> (out_valid_q && !m_tready))
		else $error("input stalled without output backpressure");

	// a held result-bearing item stays in s1 until it can be delivered
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid && out_valid_q && !m_tready) |=> valid_s1)
		else $error("result-bearing item lost while output stalled");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (item_s1.req_type == REQ_START) && !glob_q.enabled)
		|=> (glob_q.enabled && (glob_q.start_time == $past(item_s1.now))))
		else $error("start did not enable the monitor");

	a_last_close: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (item_s1.req_type == REQ_CLOSE) && item_s1.last_cpu)
		|=> (!glob_q.enabled && (glob_q.start_time == '0)))
		else $error("last close left the monitor enabled");

endmodule

// File: hw/rtl/pcss_rec_mem.sv
// Per-CPU record memory: one write port, one read port, registered read data.
// A read that hits the entry written at the same edge returns the new data.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_rec_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [pcss_pkg::CPU_W-1:0] rd_addr,
	input  logic                       wr_en,
	input  logic [pcss_pkg::CPU_W-1:0] wr_addr,
	input  pcss_pkg::pcss_rec_t        wr_data,
	output pcss_pkg::pcss_rec_t        rd_data
);
	import pcss_pkg::*;

	pcss_rec_t           mem_q [NUM_CPUS];
	logic [NUM_CPUS-1:0] valid_q;
	pcss_rec_t           rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else if (valid_q[rd_addr]) begin
				rd_q <= mem_q[rd_addr];
			end else begin
				rd_q <= '0;
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// File: hw/rtl/pcss_update.sv
// Record update logic: next per-CPU record, global state and result for one item.
// Purely combinational; sits between the memory read register and write-back.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_update (
	input  pcss_pkg::pcss_item_t item,
	input  pcss_pkg::pcss_rec_t  rec,
	input  pcss_pkg::pcss_cfg_t  cfg,
	input  pcss_pkg::pcss_glob_t glob,
	output pcss_pkg::pcss_rec_t  rec_nxt,
	output pcss_pkg::pcss_glob_t glob_nxt,
	output pcss_pkg::pcss_res_t  res,
	output logic                 res_valid
);
	import pcss_pkg::*;

	logic        old_hi;
	logic        new_hi;
	logic [63:0] idle_close;
	logic [63:0] high_close;

	assign old_hi = {1'b0, item.old_priority} < cfg.hp_limit;
	assign new_hi = {1'b0, item.new_priority} < cfg.hp_limit;

	// accumulator plus the open interval, as one three-operand add
	assign idle_close = rec.idle_accum + item.now - rec.idle_start;
	assign high_close = rec.high_accum + item.now - rec.high_start;

	always_comb begin
		rec_nxt     = rec;
		glob_nxt    = glob;
		res         = '0;
		res.cpu_out = item.cpu;
		res.status  = ST_OK;
		res_valid   = 1'b0;
		case (item.req_type)
			REQ_SWITCH: begin
				if (glob.enabled) begin
					rec_nxt.ctx_sw = rec.ctx_sw + 32'd1;
					if (!item.old_idle && item.new_idle) begin
						rec_nxt.idle_start = item.now;
					end
					if (item.old_idle && !item.new_idle) begin
						rec_nxt.idle_accum = idle_close;
						rec_nxt.idle_start = '0;
					end
					if (!old_hi && new_hi) begin
						rec_nxt.high_start = item.now;
					end
					if (old_hi && !new_hi) begin
						rec_nxt.high_accum = high_close;
						rec_nxt.high_start = '0;
					end
					if (new_hi) begin
						rec_nxt.high_sw = rec.high_sw + 32'd1;
					end
					if (!item.new_idle) begin
						rec_nxt.prio_accum = rec.prio_accum + {59'd0, item.new_priority};
						rec_nxt.prio_sw    = rec.prio_sw + 32'd1;
					end
				end
			end
			REQ_SPIN: begin
				// counts even while disabled
				rec_nxt.spin_accum = rec.spin_accum + item.spin_time;
			end
			REQ_IRQ: begin
				if (glob.enabled && (item.irq_number != cfg.tick_irq)) begin
					rec_nxt.hwi_cnt = rec.hwi_cnt + 32'd1;
					if ({1'b0, item.irq_number} < cfg.ipi_limit) begin
						rec_nxt.ipi_cnt = rec.ipi_cnt + 32'd1;
					end
				end
			end
			REQ_SEED: begin
				res_valid = 1'b1;
				if (glob.enabled) begin
					res.status = ST_ALREADY;
				end else begin
					if (item.new_idle) begin
						rec_nxt.idle_start = item.now;
					end
					if (new_hi) begin
						rec_nxt.high_start = item.now;
						rec_nxt.high_sw    = rec.high_sw + 32'd1;
					end
					if (!item.new_idle) begin
						rec_nxt.prio_accum = rec.prio_accum + {59'd0, item.new_priority};
						rec_nxt.prio_sw    = rec.prio_sw + 32'd1;
					end
				end
			end
			REQ_START: begin
				res_valid = 1'b1;
				if (glob.enabled) begin
					res.status = ST_ALREADY;
				end else begin
					glob_nxt.enabled    = 1'b1;
					glob_nxt.start_time = item.now;
				end
			end
			REQ_CLOSE: begin
				res_valid = 1'b1;
				if (!glob.enabled) begin
					res.status = ST_NOT_STARTED;
				end else begin
					res.elapsed        = item.now - glob.start_time;
					res.idle_time      = item.new_idle ? idle_close : rec.idle_accum;
					res.high_time      = new_hi ? high_close : rec.high_accum;
					res.spin_total     = rec.spin_accum;
					res.priority_sum   = rec.prio_accum;
					res.priority_count = rec.prio_sw;
					res.high_count     = rec.high_sw;
					res.switch_count   = rec.ctx_sw;
					res.irq_count      = rec.hwi_cnt;
					res.ipi_count      = rec.ipi_cnt;
					rec_nxt            = '0;
					if (item.last_cpu) begin
						glob_nxt.enabled    = 1'b0;
						glob_nxt.start_time = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
